// ===== sv/fdf_pkg.sv =====
package fdf_pkg;

  // Frame geometry
  localparam int MaxPayload  = 48;
  localparam int HeaderBytes = 7;
  localparam int StoreDepth  = HeaderBytes + MaxPayload + 1;
  localparam int AddrW       = $clog2(StoreDepth);
  localparam int CntW        = $clog2(StoreDepth + 1);

  // Register reset values
  localparam logic [7:0] StartFlagRst = 8'h02;
  localparam logic [7:0] EndFlagRst   = 8'h03;

  // Register indexes
  localparam logic RegStartFlag = 1'b0;
  localparam logic RegEndFlag   = 1'b1;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;

  // Parser field phase
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SEQ,
    PH_TYPE,
    PH_LEN,
    PH_DATA,
    PH_END
  } phase_e;

  // Controller to datapath
  typedef struct packed {
    logic append;      // store the accepted byte
    logic rd_scan;     // read the byte at the scan position
    logic exec;        // parse the current byte
    logic emit_rd;     // start one result of the frame run
    logic emit_ld;     // load a payload byte into the result register
    logic drop_frame;  // drop the emitted frame from the store
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bypass_ok;   // room to store, byte can be parsed directly
    logic more;        // stored bytes still wait to be scanned
    logic end_match;   // end flag seen in the end slot
    logic len_zero;    // frame has no payload
    logic out_last;    // result register holds the last result
  } stat_t;

  // Circular store address: base plus offset, wrapped at the depth
  function automatic addr_t wrap_add(addr_t base, cnt_t off);
    logic [CntW:0] sum;
    sum = (CntW+1)'(base) + (CntW+1)'(off);
    if (sum >= (CntW+1)'(StoreDepth)) begin
      sum = sum - (CntW+1)'(StoreDepth);
    end
    return AddrW'(sum);
  endfunction

endpackage

// ===== sv/framed_packet_deframer_core.sv =====
// A clean byte is parsed in the cycle after acceptance; a new byte is accepted only once the last
// one is parsed, and not while a frame closes or stored bytes are replayed. Each replayed byte takes a
// stored-byte read on the single store read port followed by the parse step. A closing frame gives
// its results one at a time (read, load, handshake), or read and handshake for the empty-frame marker.
// Reset (rst_ni low, asynchronous) empties the store, returns the parser to start-flag hunt and
// loads start flag 0x02 and end flag 0x03.
module framed_packet_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] seq_number, [23:16] frame_type, [29:24] payload_length,
  // [37:30] payload_byte, [39:38] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] byte_valid
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  fdf_pkg::cmd_t  cmd;
  fdf_pkg::stat_t stat;
  logic [15:0]    seq;
  logic [7:0]     ftype;
  logic [5:0]     plen;
  logic [7:0]     pbyte;

  fdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fdf_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_byte_i (s_axis_tdata),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .seq_o     (seq),
    .type_o    (ftype),
    .len_o     (plen),
    .byte_o    (pbyte),
    .bvalid_o  (m_axis_tuser),
    .last_o    (m_axis_tlast)
  );

  // Pack the result fields
  assign m_axis_tdata = {2'b00, pbyte, plen, ftype, seq};

endmodule

// ===== sv/fdf_ram.sv =====
module fdf_ram #(
  parameter int Width = 8,
  parameter int Depth = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fdf_ctrl.sv =====
module fdf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fdf_pkg::stat_t stat_i,
  output fdf_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;
  logic   valid_q;

  // Sequence the datapath
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.append = 1'b1;
          state_d      = stat_i.bypass_ok ? ST_EXEC : ST_READ;
        end
      end
      ST_READ: begin
        if (stat_i.more) begin
          cmd_o.rd_scan = 1'b1;
          state_d       = ST_EXEC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EXEC: begin
        if (stat_i.end_match) begin
          state_d = ST_EMIT_RD;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.more ? ST_READ : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = stat_i.len_zero ? ST_HOLD : ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.emit_ld = 1'b1;
        state_d       = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready_i && valid_q) begin
          if (stat_i.out_last) begin
            cmd_o.drop_frame = 1'b1;
            state_d          = stat_i.more ? ST_READ : ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
      valid_q <= (state_d == ST_HOLD);
    end
  end

  assign in_ready_o  = ready_q;
  assign out_valid_o = valid_q;

endmodule

// ===== sv/fdf_datapath.sv =====
module fdf_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fdf_pkg::cmd_t  cmd_i,
  output fdf_pkg::stat_t stat_o,
  input  logic [7:0]     in_byte_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [7:0]     cfg_data_i,
  output logic [15:0]    seq_o,
  output logic [7:0]     type_o,
  output logic [5:0]     len_o,
  output logic [7:0]     byte_o,
  output logic           bvalid_o,
  output logic           last_o
);

  // Configuration
  logic [7:0] start_q, end_q;

  // Store pointers and parser
  fdf_pkg::addr_t  base_q, base_d;
  fdf_pkg::cnt_t   count_q, count_d;
  fdf_pkg::cnt_t   scan_q, scan_d;
  fdf_pkg::cnt_t   fidx_q, fidx_d;
  fdf_pkg::cnt_t   eidx_q, eidx_d;
  fdf_pkg::phase_e phase_q, phase_d;
  logic [15:0]     seq_q, seq_d;
  logic [7:0]      type_q, type_d;
  logic [15:0]     len_q, len_d;

  // Bypass of the byte just stored
  logic [7:0] byte_q, byte_d;
  logic       byp_q, byp_d;

  // Result register
  logic [7:0] obyte_q, obyte_d;
  logic       obv_q, obv_d;
  logic       olast_q, olast_d;

  // Store port signals
  logic           we, re;
  fdf_pkg::addr_t waddr, raddr;
  fdf_pkg::cnt_t  roff;
  logic [7:0]     rdata;
  logic [7:0]     cur;
  logic [15:0]    new_len;
  logic           do_drop;
  fdf_pkg::cnt_t  drop_n;

  fdf_ram #(
    .Width(8),
    .Depth(fdf_pkg::StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(in_byte_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign cur     = byp_q ? byte_q : rdata;
  assign new_len = {cur, len_q[7:0]};
  assign waddr   = fdf_pkg::wrap_add(base_q, count_q);
  assign roff    = cmd_i.emit_rd ? fdf_pkg::cnt_t'(fdf_pkg::HeaderBytes) + eidx_q : scan_q;
  assign raddr   = fdf_pkg::wrap_add(base_q, roff);

  // Parse, store and emit
  always_comb begin
    base_d  = base_q;
    count_d = count_q;
    scan_d  = scan_q;
    fidx_d  = fidx_q;
    eidx_d  = eidx_q;
    phase_d = phase_q;
    seq_d   = seq_q;
    type_d  = type_q;
    len_d   = len_q;
    byte_d  = byte_q;
    byp_d   = byp_q;
    obyte_d = obyte_q;
    obv_d   = obv_q;
    olast_d = olast_q;
    we      = 1'b0;
    re      = 1'b0;
    do_drop = 1'b0;
    drop_n  = fdf_pkg::cnt_t'(1);

    // Append the accepted byte, keep a copy for direct parsing
    if (cmd_i.append) begin
      if (count_q < fdf_pkg::cnt_t'(fdf_pkg::StoreDepth)) begin
        we      = 1'b1;
        count_d = count_q + fdf_pkg::cnt_t'(1);
        byte_d  = in_byte_i;
        byp_d   = 1'b1;
      end else begin
        byp_d = 1'b0;
      end
    end

    if (cmd_i.rd_scan) begin
      re    = 1'b1;
      byp_d = 1'b0;
    end

    // Advance the parser by one byte
    if (cmd_i.exec) begin
      case (phase_q)
        fdf_pkg::PH_HUNT: begin
          if (cur == start_q) begin
            phase_d = fdf_pkg::PH_SEQ;
            fidx_d  = '0;
            scan_d  = fdf_pkg::cnt_t'(1);
          end else begin
            do_drop = 1'b1;
          end
        end
        fdf_pkg::PH_SEQ: begin
          if (fidx_q == '0) begin
            seq_d = {8'h00, cur};
          end else begin
            seq_d = {cur, seq_q[7:0]};
          end
          scan_d = scan_q + fdf_pkg::cnt_t'(1);
          fidx_d = fidx_q + fdf_pkg::cnt_t'(1);
          if (fidx_q != '0) begin
            phase_d = fdf_pkg::PH_TYPE;
            fidx_d  = '0;
          end
        end
        fdf_pkg::PH_TYPE: begin
          if (fidx_q == '0) begin
            type_d = cur;
          end
          scan_d = scan_q + fdf_pkg::cnt_t'(1);
          fidx_d = fidx_q + fdf_pkg::cnt_t'(1);
          if (fidx_q != '0) begin
            phase_d = fdf_pkg::PH_LEN;
            fidx_d  = '0;
          end
        end
        fdf_pkg::PH_LEN: begin
          scan_d = scan_q + fdf_pkg::cnt_t'(1);
          if (fidx_q == '0) begin
            len_d  = {8'h00, cur};
            fidx_d = fidx_q + fdf_pkg::cnt_t'(1);
          end else begin
            len_d  = new_len;
            fidx_d = '0;
            if (new_len > 16'(fdf_pkg::MaxPayload)) begin
              do_drop = 1'b1;
            end else if (new_len == 16'h0000) begin
              phase_d = fdf_pkg::PH_END;
            end else begin
              phase_d = fdf_pkg::PH_DATA;
            end
          end
        end
        fdf_pkg::PH_DATA: begin
          scan_d = scan_q + fdf_pkg::cnt_t'(1);
          fidx_d = fidx_q + fdf_pkg::cnt_t'(1);
          if ((16'(fidx_q) + 16'h0001) >= len_q) begin
            phase_d = fdf_pkg::PH_END;
            fidx_d  = '0;
          end
        end
        default: begin
          // Wrong end flag: drop the start flag and rescan
          do_drop = 1'b1;
        end
      endcase
    end

    // Start one result: marker for an empty frame, else fetch a payload byte
    if (cmd_i.emit_rd) begin
      if (len_q == 16'h0000) begin
        obyte_d = 8'h00;
        obv_d   = 1'b0;
        olast_d = 1'b1;
      end else begin
        re = 1'b1;
      end
    end

    if (cmd_i.emit_ld) begin
      obyte_d = rdata;
      obv_d   = 1'b1;
      olast_d = ((eidx_q + fdf_pkg::cnt_t'(1)) == fdf_pkg::cnt_t'(len_q[5:0]));
      eidx_d  = eidx_q + fdf_pkg::cnt_t'(1);
    end

    // Drop the whole frame up to its end flag
    if (cmd_i.drop_frame) begin
      do_drop = 1'b1;
      drop_n  = scan_q + fdf_pkg::cnt_t'(1);
    end

    if (do_drop) begin
      count_d = (drop_n >= count_q) ? '0 : count_q - drop_n;
      base_d  = fdf_pkg::wrap_add(base_q, drop_n);
      scan_d  = '0;
      fidx_d  = '0;
      eidx_d  = '0;
      phase_d = fdf_pkg::PH_HUNT;
    end
  end

  // Status to the controller
  assign stat_o.bypass_ok = (count_q < fdf_pkg::cnt_t'(fdf_pkg::StoreDepth));
  assign stat_o.more      = (scan_d < count_d);
  assign stat_o.end_match = (phase_q == fdf_pkg::PH_END) && (cur == end_q);
  assign stat_o.len_zero  = (len_q == 16'h0000);
  assign stat_o.out_last  = olast_q;

  // Control and header registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= fdf_pkg::StartFlagRst;
      end_q   <= fdf_pkg::EndFlagRst;
      base_q  <= '0;
      count_q <= '0;
      scan_q  <= '0;
      fidx_q  <= '0;
      eidx_q  <= '0;
      phase_q <= fdf_pkg::PH_HUNT;
      seq_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      byp_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fdf_pkg::RegStartFlag: start_q <= cfg_data_i;
          fdf_pkg::RegEndFlag:   end_q   <= cfg_data_i;
          default: ;
        endcase
      end
      base_q  <= base_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      fidx_q  <= fidx_d;
      eidx_q  <= eidx_d;
      phase_q <= phase_d;
      seq_q   <= seq_d;
      type_q  <= type_d;
      len_q   <= len_d;
      byp_q   <= byp_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    obyte_q <= obyte_d;
    obv_q   <= obv_d;
    olast_q <= olast_d;
  end

  assign seq_o    = seq_q;
  assign type_o   = type_q;
  assign len_o    = len_q[5:0];
  assign byte_o   = obyte_q;
  assign bvalid_o = obv_q;
  assign last_o   = olast_q;

endmodule

// ===== sim/fdf_frame_checker.sv =====
module fdf_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] seq_number, [23:16] frame_type, [29:24] payload_length,
  // [37:30] payload_byte, [39:38] zero
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tuser,   // [0] byte_valid
  input  logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned frames_o,
  output int unsigned results_o
);

  typedef struct {
    logic [15:0] seq;
    logic [7:0]  ftype;
    logic [5:0]  plen;
    logic [7:0]  pbyte;
    logic        bvalid;
    logic        blast;
  } frame_result_t;

  frame_result_t due_results[$];

  // Shadow of the deframer state
  logic [7:0]      fstore [fdf_pkg::StoreDepth];
  int unsigned     st_cnt;
  int unsigned     scan_pos;
  int unsigned     fidx;
  fdf_pkg::phase_e phase;
  logic [15:0]     h_seq;
  logic [7:0]      h_type;
  logic [15:0]     h_len;
  logic [7:0]      start_flag;
  logic [7:0]      end_flag;

  int unsigned errors       = 0;
  int unsigned frames_done  = 0;
  int unsigned results_seen = 0;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h",
             results_seen, what, got, want);
    errors++;
  endtask

  // Drop n bytes from the head of the store and go back to hunting
  function automatic void discard_head(input int unsigned n);
    if (n >= st_cnt) begin
      st_cnt = 0;
    end else begin
      for (int unsigned k = 0; k < st_cnt - n; k++) begin
        fstore[fdf_pkg::addr_t'(k)] = fstore[fdf_pkg::addr_t'(k + n)];
      end
      st_cnt = st_cnt - n;
    end
    scan_pos = 0;
    phase    = fdf_pkg::PH_HUNT;
    fidx     = 0;
  endfunction

  // Queue the payload run of a closed frame, or its empty marker
  function automatic void queue_frame_run();
    frame_result_t r;
    r.seq   = h_seq;
    r.ftype = h_type;
    r.plen  = h_len[5:0];
    frames_done++;
    if (h_len == 16'h0000) begin
      r.pbyte  = 8'h00;
      r.bvalid = 1'b0;
      r.blast  = 1'b1;
      due_results = {due_results, r};
    end else begin
      for (int unsigned i = 0; i < 32'(h_len); i++) begin
        r.pbyte  = fstore[fdf_pkg::addr_t'(fdf_pkg::HeaderBytes + i)];
        r.bvalid = 1'b1;
        r.blast  = (i + 1 == 32'(h_len));
        due_results = {due_results, r};
      end
    end
  endfunction

  // Store one received byte and scan as far as the stored bytes allow
  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [7:0] c;
    if (st_cnt < fdf_pkg::StoreDepth) begin
      fstore[fdf_pkg::addr_t'(st_cnt)] = b;
      st_cnt++;
    end
    while (scan_pos < st_cnt) begin
      c = fstore[fdf_pkg::addr_t'(scan_pos)];
      case (phase)
        fdf_pkg::PH_HUNT: begin
          if (c == start_flag) begin
            phase    = fdf_pkg::PH_SEQ;
            fidx     = 0;
            scan_pos = 1;
          end else begin
            discard_head(1);
          end
        end
        fdf_pkg::PH_SEQ: begin
          if (fidx == 0) h_seq = {8'h00, c};
          else h_seq[15:8] = c;
          scan_pos++;
          fidx++;
          if (fidx >= 2) begin
            phase = fdf_pkg::PH_TYPE;
            fidx  = 0;
          end
        end
        fdf_pkg::PH_TYPE: begin
          // high type byte is consumed and ignored
          if (fidx == 0) h_type = c;
          scan_pos++;
          fidx++;
          if (fidx >= 2) begin
            phase = fdf_pkg::PH_LEN;
            fidx  = 0;
          end
        end
        fdf_pkg::PH_LEN: begin
          if (fidx == 0) h_len = {8'h00, c};
          else h_len[15:8] = c;
          scan_pos++;
          fidx++;
          if (fidx >= 2) begin
            fidx = 0;
            if (h_len > 16'(fdf_pkg::MaxPayload)) discard_head(1);
            else if (h_len == 16'h0000) phase = fdf_pkg::PH_END;
            else phase = fdf_pkg::PH_DATA;
          end
        end
        fdf_pkg::PH_DATA: begin
          scan_pos++;
          fidx++;
          if (fidx >= 32'(h_len)) begin
            phase = fdf_pkg::PH_END;
            fidx  = 0;
          end
        end
        default: begin
          if (c == end_flag) begin
            queue_frame_run();
            discard_head(scan_pos + 1);
          end else begin
            discard_head(1);
          end
        end
      endcase
    end
  endfunction

  // Watch all channels at each edge: results first, then new requests
  always @(posedge clk_i) begin : watch
    frame_result_t want;
    if (!rst_ni) begin
      st_cnt     = 0;
      scan_pos   = 0;
      fidx       = 0;
      phase      = fdf_pkg::PH_HUNT;
      h_seq      = '0;
      h_type     = '0;
      h_len      = '0;
      start_flag = fdf_pkg::StartFlagRst;
      end_flag   = fdf_pkg::EndFlagRst;
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fdf_pkg::RegStartFlag: start_flag = cfg_data_i;
          fdf_pkg::RegEndFlag:   end_flag   = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result, seq_number", m_axis_tdata[15:0], 16'h0);
        end else begin
          want = due_results.pop_front();
          if (m_axis_tdata[15:0] !== want.seq)
            report_mismatch("seq_number", m_axis_tdata[15:0], want.seq);
          if (m_axis_tdata[23:16] !== want.ftype)
            report_mismatch("frame_type", 16'(m_axis_tdata[23:16]), 16'(want.ftype));
          if (m_axis_tdata[29:24] !== want.plen)
            report_mismatch("payload_length", 16'(m_axis_tdata[29:24]), 16'(want.plen));
          if (m_axis_tdata[37:30] !== want.pbyte)
            report_mismatch("payload_byte", 16'(m_axis_tdata[37:30]), 16'(want.pbyte));
          if (m_axis_tuser !== want.bvalid)
            report_mismatch("byte_valid", 16'(m_axis_tuser), 16'(want.bvalid));
          if (m_axis_tlast !== want.blast)
            report_mismatch("last", 16'(m_axis_tlast), 16'(want.blast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata);
    end
    fail_count_o <= errors;
    pending_o    <= due_results.size();
    frames_o     <= frames_done;
    results_o    <= results_seen;
  end

endmodule

// ===== sim/tb.sv =====
module tb;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [15:0] seq_number, [23:16] frame_type, [29:24] payload_length,
  // [37:30] payload_byte, [39:38] zero
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;   // [0] byte_valid
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned frames_closed;
  int unsigned results_taken;

  int unsigned bytes_sent   = 0;
  int unsigned settings_run = 1;
  int unsigned cycles       = 0;
  int unsigned stall_left   = 0;
  int unsigned calm_left    = 0;
  bit          sender_calm  = 1'b0;

  framed_packet_deframer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  fdf_frame_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .frames_o      (frames_closed),
    .results_o     (results_taken)
  );

  always #2 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("framed_packet_deframer_core test failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the result side at random, with calm stretches
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (calm_left != 0) calm_left--;
      else if ($urandom_range(0, 199) == 0) calm_left = 300;
      else if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  // Offer one byte after an optional gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= b;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Hold off the sender until every pending result has come out and the
  // block has finished scanning its stored bytes
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Write both flag registers back to back
  task automatic write_flags(input logic [7:0] sflag, input logic [7:0] eflag);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= fdf_pkg::RegStartFlag;
    cfg_data_i <= sflag;
    @(posedge clk_i);
    cfg_idx_i  <= fdf_pkg::RegEndFlag;
    cfg_data_i <= eflag;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_run++;
  endtask

  // Send one frame: mostly well formed, some oversized or badly closed
  task automatic send_frame(input logic [7:0] sflag, input logic [7:0] eflag,
                            input bit force_max);
    int unsigned kind;
    int unsigned plen;
    logic [15:0] len_field;
    kind = force_max ? 0 : $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
    plen = (kind < 6) ? fdf_pkg::MaxPayload : $urandom_range(0, 6);
    len_field = 16'(plen);
    if (kind >= 6 && kind < 14) begin
      if (kind < 10) len_field = 16'($urandom_range(fdf_pkg::MaxPayload + 1, 255));
      else len_field = {8'($urandom_range(1, 255)), 8'($urandom)};
    end
    send_byte(sflag);
    repeat (4) send_byte(8'($urandom));
    send_byte(len_field[7:0]);
    send_byte(len_field[15:8]);
    if (len_field > 16'(fdf_pkg::MaxPayload)) return;
    repeat (plen) send_byte(8'($urandom));
    if (kind >= 14 && kind < 24) send_byte(eflag ^ 8'($urandom_range(1, 255)));
    else send_byte(eflag);
  endtask

  initial begin
    logic [7:0]  directed[$];
    logic [7:0]  sflag;
    logic [7:0]  eflag;
    int unsigned budget;
    int unsigned frame_no;
    int unsigned pause_at;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = fdf_pkg::RegStartFlag;
    cfg_data_i    = 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at the reset flags: empty frame with all-ones header,
    // oversized length, end slot holding a start flag that opens the next
    // frame, and a two-byte payload of both extremes
    directed = '{8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h03,
                 8'h02, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h31, 8'h00,
                 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
                 8'h34, 8'h12, 8'h7F, 8'h80, 8'h02, 8'h00, 8'h00, 8'hFF, 8'h03};
    foreach (directed[i]) send_byte(directed[i]);

    // Random frames under several flag settings, extremes first
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       {sflag, eflag} = {8'h00, 8'hFF};
        1:       {sflag, eflag} = {8'hFF, 8'h00};
        2:       {sflag, eflag} = {8'h7E, 8'h7E};
        default: {sflag, eflag} = {8'($urandom), 8'($urandom)};
      endcase
      settle();
      repeat (DrainWait) @(posedge clk_i);
      write_flags(sflag, eflag);
      sender_calm = (p == 2);
      budget   = bytes_sent + 40;
      frame_no = 0;
      pause_at = $urandom_range(1, 4);
      while (bytes_sent < budget) begin
        send_frame(sflag, eflag, (p == 0) && (frame_no == 0));
        frame_no++;
        if (frame_no == pause_at) settle();
      end
    end

    settle();
    repeat (DrainWait) @(posedge clk_i);

    $display("sent %0d bytes under %0d flag settings", bytes_sent, settings_run);
    $display("checked %0d results from %0d closed frames", results_taken, frames_closed);
    if (fail_count == 0 && pending == 0) begin
      $display("framed_packet_deframer_core test passed");
    end else begin
      $display("framed_packet_deframer_core test failed");
    end
    $finish;
  end

endmodule
